// File: hw/rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants of the log-scale meter mapper.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int XW       = 32;  // log2 operand width
  localparam int NW       = 5;   // leading-one index width
  localparam int LOG_FRAC = 16;  // log2 fraction bits
  localparam int LOGW     = NW + LOG_FRAC;
  localparam int RMW      = 12;  // result_max / position width
  localparam int PRODW    = RMW + LOGW;
  localparam int LOG_LAT  = LOG_FRAC + 1;
  localparam int DIV_LAT  = RMW + 2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FULL_SCALE   = 2'd0;
  localparam cfg_idx_t REG_RESULT_MAX   = 2'd1;
  localparam cfg_idx_t REG_FLATTEN      = 2'd2;
  localparam cfg_idx_t REG_INPUT_OFFSET = 2'd3;

  typedef logic [LOGW-1:0] log_t;

endpackage

// File: hw/rtl/lsm_log2.sv
// ----------------------------------------------------------------------------
// lsm_log2
// Pipelined log2 in Q.16: normalize stage, then one squaring per stage.
// ----------------------------------------------------------------------------
module lsm_log2 import lsm_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output log_t          y
);

  logic [NW-1:0]       n_r    [0:LOG_FRAC];
  logic [XW-1:0]       m_r    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_r [0:LOG_FRAC];
  logic [XW-1:0]       m_nxt  [1:LOG_FRAC];
  logic                b_nxt  [1:LOG_FRAC];

  logic [NW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) lead = NW'(i);
    end
  end

  // square of a Q1.31 mantissa, kept as Q2.31 before the halving step
  always_comb begin
    logic [2*XW-1:0] sq;
    logic [XW:0]     t;
    sq = '0;
    t  = '0;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      sq       = m_r[k-1] * m_r[k-1];
      t        = sq[2*XW-1:XW-1];
      b_nxt[k] = t[XW];
      m_nxt[k] = t[XW] ? t[XW:1] : t[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= lead;
      m_r[0]    <= x << (NW'(XW - 1) - lead);
      frac_r[0] <= '0;
      for (int k = 1; k <= LOG_FRAC; k++) begin
        n_r[k]    <= n_r[k-1];
        m_r[k]    <= m_nxt[k];
        frac_r[k] <= {frac_r[k-1][LOG_FRAC-2:0], b_nxt[k]};
      end
    end
  end

  assign y = {n_r[LOG_FRAC], frac_r[LOG_FRAC]};

endmodule

// File: hw/rtl/lsm_div.sv
// ----------------------------------------------------------------------------
// lsm_div
// Scale, overflow check and one-bit-per-stage restoring divide with saturation;
// a zero denominator gives a zero result.
module lsm_div import lsm_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  log_t           ln,
  input  log_t           lf,
  input  log_t           ld,
  input  logic [RMW-1:0] rmax,
  output logic [RMW-1:0] q
);

  logic [PRODW-1:0] prod_r;
  logic [LOGW-1:0]  den0_r;
  logic [RMW-1:0]   rm0_r;
  logic [LOGW-1:0]  num;
  logic [LOGW-1:0]  den;

  assign num = (ln > lf) ? (ln - lf) : '0;
  assign den = (ld > lf) ? (ld - lf) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PRODW'(rmax) * PRODW'(num);
      den0_r <= den;
      rm0_r  <= rmax;
    end
  end

  logic [PRODW-1:0] rem_r   [0:RMW];
  logic [LOGW-1:0]  den_r   [0:RMW];
  logic [RMW-1:0]   rm_r    [0:RMW];
  logic [RMW-1:0]   quo_r   [0:RMW];
  logic             ovf_r   [0:RMW];
  logic             zero_r  [0:RMW];
  logic [PRODW-1:0] rem_nxt [1:RMW];
  logic             qb_nxt  [1:RMW];

  always_comb begin
    logic [PRODW-1:0] dsh;
    dsh = '0;
    for (int k = 1; k <= RMW; k++) begin
      dsh        = PRODW'(den_r[k-1]) << (RMW - k);
      qb_nxt[k]  = rem_r[k-1] >= dsh;
      rem_nxt[k] = qb_nxt[k] ? rem_r[k-1] - dsh : rem_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= prod_r;
      den_r[0]  <= den0_r;
      rm_r[0]   <= rm0_r;
      quo_r[0]  <= '0;
      ovf_r[0]  <= prod_r >= (PRODW'(den0_r) << RMW);
      zero_r[0] <= (den0_r == '0);
      for (int k = 1; k <= RMW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_r[k-1];
        rm_r[k]   <= rm_r[k-1];
        quo_r[k]  <= {quo_r[k-1][RMW-2:0], qb_nxt[k]};
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[RMW]) begin
      q = '0;
    end else if (ovf_r[RMW] || (quo_r[RMW] > rm_r[RMW])) begin
      q = rm_r[RMW];
    end else begin
      q = quo_r[RMW];
    end
  end

endmodule

// File: hw/rtl/log_scale_meter_mapper_unit.sv
// ----------------------------------------------------------------------------
// log_scale_meter_mapper_unit
// Maps a Q16.8 sample to a logarithmic bargraph position.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_sample: a transfer happens when in_valid
// is high and in_stall low. Output channel out_valid/out_stall/out_position
// works the same way with this block driving out_valid.
// The pipeline takes one sample per cycle while the receiver does not stall.
// From input transfer to out_valid a sample passes one input stage, 17 stages
// of the log2 unit (one squaring multiplier per stage) and 14 stages of scale
// and restoring divide (one quotient bit per stage), plus the output register.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and in_stall is raised; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults (full_scale 250.0, result_max 100, flatten 40.0, offset 0). The
// user must write registers on cfg_we/cfg_index/cfg_data while idle; unchecked.
// ----------------------------------------------------------------------------
module log_scale_meter_mapper_unit import lsm_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [23:0]    in_sample,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [RMW-1:0] out_position,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  logic [23:0]    cfg_data
);

  localparam int DEPTH = 1 + LOG_LAT + DIV_LAT;

  logic [23:0]    full_scale_r;
  logic [RMW-1:0] result_max_r;
  logic [15:0]    flatten_r;
  logic [23:0]    offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= 24'd64000;
      result_max_r <= 12'd100;
      flatten_r    <= 16'd10240;
      offset_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_SCALE:   full_scale_r <= cfg_data;
        REG_RESULT_MAX:   result_max_r <= cfg_data[RMW-1:0];
        REG_FLATTEN:      flatten_r    <= cfg_data[15:0];
        REG_INPUT_OFFSET: offset_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [DEPTH-1:0] v_r;
  logic             out_valid_r;
  logic [RMW-1:0]   out_position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[DEPTH-2:0], in_valid};
      out_valid_r <= v_r[DEPTH-1];
    end
  end

  logic [XW-1:0] f_al;
  logic [XW-1:0] f;
  logic [23:0]   d;
  assign f_al = (XW'(flatten_r) << FRAC_BITS) >> 8;
  assign f    = (f_al == '0) ? XW'(1) : f_al;
  assign d    = (in_sample > offset_r) ? (in_sample - offset_r) : '0;

  logic [XW-1:0] xf_r, xn_r, xd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xf_r <= f;
      xn_r <= f + XW'(d);
      xd_r <= f + XW'(full_scale_r);
    end
  end

  log_t lf, ln, ld;
  lsm_log2 u_log_f (.clk(clk), .en(en), .x(xf_r), .y(lf));
  lsm_log2 u_log_n (.clk(clk), .en(en), .x(xn_r), .y(ln));
  lsm_log2 u_log_d (.clk(clk), .en(en), .x(xd_r), .y(ld));

  logic [RMW-1:0] q;
  lsm_div u_div (
    .clk(clk), .en(en), .ln(ln), .lf(lf), .ld(ld), .rmax(result_max_r), .q(q)
  );

  always_ff @(posedge clk) begin
    if (en) out_position_r <= q;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;

endmodule
